// ----- src/lpht_pkg.sv -----
// Shared types and constants of the linear-probing hash table.
// No dependencies; every other file of the block refers to it by scoped names.
package lpht_pkg;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned CFG_W = 9;

  localparam logic [KEY_W-1:0] EMPTY_KEY  = 16'hFFFF;
  localparam logic [VAL_W-1:0] NO_VALUE   = 16'hFFFF;
  localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

  // The home slot is found four key bits at a time.
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_STEPS = KEY_W / DIV_BITS;

  typedef enum logic [1:0] {
    REQ_GET    = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef struct packed {
    req_e             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] read_value;
    logic             ok;
  } result_t;

endpackage

// ----- src/linear_probe_hash_table_top.sv -----
// Top level of the linear-probing hash table of 16-bit keys and values.
// Depends on lpht_pkg and instantiates lpht_front, lpht_queue and lpht_back.
//
//   Channel   | Handshake             | Payload
//   ----------+-----------------------+--------------------------------------
//   request   | start, busy           | req_type_i, key_i, value_i
//   result    | done_o (one cycle)    | read_value_o, ok_o
//   config    | cfg_we_i              | cfg_wdata_i (table_size)
//
// A request is taken at a rising edge where start is high and busy is low.
// The front end works out the home slot (key modulo the size in use, four key
// bits per cycle) and can take the next request in its last cycle while the
// queue has room, so a new request enters as the last one is pushed.
// The probe engine reads the home slot when it pops a request and then walks
// the probe run one slot at a time until a slot matches or it has visited as
// many slots as the size in use.
// After reset the slot memories are cleared slot by slot with busy held
// high; configuration writes are still taken then. The result strobe cannot be
// stalled by the receiver.
module linear_probe_hash_table_top #(
  parameter int unsigned MAX_SLOTS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type_i,
  input  logic [lpht_pkg::KEY_W-1:0]    key_i,
  input  logic [lpht_pkg::VAL_W-1:0]    value_i,
  output logic                          done_o,
  output logic [lpht_pkg::VAL_W-1:0]    read_value_o,
  output logic                          ok_o,
  input  logic                          cfg_we_i,
  input  logic [lpht_pkg::CFG_W-1:0]    cfg_wdata_i
);

  localparam int unsigned SIZE_W  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_SLOTS);
  localparam int unsigned CMP_W   = (SIZE_W > lpht_pkg::CFG_W) ? SIZE_W : lpht_pkg::CFG_W;
  localparam int unsigned REQ_BITS = $bits(lpht_pkg::req_t);
  localparam int unsigned QDATA_W = REQ_BITS + IDX_W;
  localparam int unsigned QDEPTH  = 2;

  // The size register is kept as written; the size in use is clamped to
  // one slot at the low end and to the memory depth at the high end.
  logic [lpht_pkg::CFG_W-1:0] table_size_q;
  logic [CMP_W-1:0]           size_ext;
  logic [SIZE_W-1:0]          size_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= lpht_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      table_size_q <= cfg_wdata_i;
    end
  end

  assign size_ext = CMP_W'(table_size_q);

  always_comb begin
    priority if (size_ext == '0) begin
      size_use = SIZE_W'(1);
    end else if (size_ext > CMP_W'(MAX_SLOTS)) begin
      size_use = SIZE_W'(MAX_SLOTS);
    end else begin
      size_use = size_ext[SIZE_W-1:0];
    end
  end

  lpht_pkg::req_t       in_req;
  lpht_pkg::req_t       push_req;
  lpht_pkg::req_t       pop_req;
  lpht_pkg::fifo_stat_t fifo_stat;
  lpht_pkg::result_t    result;
  logic                 front_ready;
  logic                 clearing;
  logic                 push;
  logic                 pop;
  logic [IDX_W-1:0]     push_home;
  logic [IDX_W-1:0]     pop_home;
  logic [QDATA_W-1:0]   q_in;
  logic [QDATA_W-1:0]   q_out;

  assign in_req.op    = lpht_pkg::req_e'(req_type_i);
  assign in_req.key   = key_i;
  assign in_req.value = value_i;

  // No request is taken while the slot memories are being cleared.
  assign busy = !front_ready || clearing;

  lpht_front #(
    .SIZE_W (SIZE_W),
    .IDX_W  (IDX_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start && !clearing),
    .req_i       (in_req),
    .size_i      (size_use),
    .fifo_i      (fifo_stat),
    .ready_o     (front_ready),
    .push_o      (push),
    .push_req_o  (push_req),
    .push_home_o (push_home)
  );

  assign q_in = {push_req, push_home};

  lpht_queue #(
    .DATA_W (QDATA_W),
    .DEPTH  (QDEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_in),
    .pop_i  (pop),
    .data_o (q_out),
    .stat_o (fifo_stat)
  );

  assign pop_req  = lpht_pkg::req_t'(q_out[QDATA_W-1:IDX_W]);
  assign pop_home = q_out[IDX_W-1:0];

  lpht_back #(
    .MAX_SLOTS (MAX_SLOTS),
    .SIZE_W    (SIZE_W),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size_use),
    .entry_i    (pop_req),
    .home_i     (pop_home),
    .stat_i     (fifo_stat),
    .pop_o      (pop),
    .clearing_o (clearing),
    .result_o   (result)
  );

  assign done_o       = result.done;
  assign read_value_o = result.read_value;
  assign ok_o         = result.ok;

endmodule

// ----- src/lpht_front.sv -----
// Front end of the hash table: accepts requests and computes the home slot.
// Depends on lpht_pkg; feeds lpht_queue.
module lpht_front #(
  parameter int unsigned SIZE_W = 9,
  parameter int unsigned IDX_W  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  lpht_pkg::req_t       req_i,
  input  logic [SIZE_W-1:0]    size_i,
  input  lpht_pkg::fifo_stat_t fifo_i,
  output logic                 ready_o,
  output logic                 push_o,
  output lpht_pkg::req_t       push_req_o,
  output logic [IDX_W-1:0]     push_home_o
);

  localparam int unsigned STEP_W = $clog2(lpht_pkg::DIV_STEPS);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_HOLD
  } fstate_e;

  fstate_e                   state_q, state_d;
  lpht_pkg::req_t            req_q, req_d;
  logic [lpht_pkg::KEY_W-1:0] sh_q, sh_d;
  logic [SIZE_W-1:0]         rem_q, rem_d;
  logic [STEP_W-1:0]         step_q, step_d;

  logic [SIZE_W:0]   trial;
  logic [SIZE_W-1:0] rem_v;
  logic [SIZE_W-1:0] rem_step;
  logic              last;

  // Restoring remainder, a few key bits per cycle, most significant first.
  always_comb begin
    rem_v = rem_q;
    trial = '0;
    for (int b = 0; b < lpht_pkg::DIV_BITS; b++) begin
      trial = {rem_v, sh_q[lpht_pkg::KEY_W-1-b]};
      if (trial >= {1'b0, size_i}) begin
        trial = trial - {1'b0, size_i};
      end
      rem_v = trial[SIZE_W-1:0];
    end
    rem_step = rem_v;
  end

  assign last        = (step_q == STEP_W'(lpht_pkg::DIV_STEPS - 1));
  assign push_o      = ((state_q == F_DIV) && last) || (state_q == F_HOLD);
  assign push_req_o  = req_q;
  assign push_home_o = (state_q == F_HOLD) ? rem_q[IDX_W-1:0] : rem_step[IDX_W-1:0];
  assign ready_o     = (state_q == F_IDLE) || (push_o && !fifo_i.full);

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    sh_d    = sh_q;
    rem_d   = rem_q;
    step_d  = step_q;
    priority if (start_i && ready_o) begin
      req_d   = req_i;
      sh_d    = req_i.key;
      rem_d   = '0;
      step_d  = '0;
      state_d = F_DIV;
    end else begin
      unique case (state_q)
        F_IDLE: begin
        end
        F_DIV: begin
          rem_d  = rem_step;
          sh_d   = sh_q << lpht_pkg::DIV_BITS;
          step_d = STEP_W'(step_q + STEP_W'(1));
          if (last) begin
            state_d = fifo_i.full ? F_HOLD : F_IDLE;
          end
        end
        F_HOLD: begin
          if (!fifo_i.full) begin
            state_d = F_IDLE;
          end
        end
        default: state_d = F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      req_q   <= '0;
      sh_q    <= '0;
      rem_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
      sh_q    <= sh_d;
      rem_q   <= rem_d;
      step_q  <= step_d;
    end
  end

endmodule

// ----- src/lpht_queue.sv -----
// Small request queue between the front end and the probe engine.
// Depends on lpht_pkg for the status type.
module lpht_queue #(
  parameter int unsigned DATA_W = 43,
  parameter int unsigned DEPTH  = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DATA_W-1:0]    data_i,
  input  logic                 pop_i,
  output logic [DATA_W-1:0]    data_o,
  output lpht_pkg::fifo_stat_t stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + PTR_W'(1));
  endfunction

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= bump(wr_q);
      end
      if (do_pop) begin
        rd_q <= bump(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= CNT_W'(cnt_q + CNT_W'(1));
      end else if (do_pop && !do_push) begin
        cnt_q <= CNT_W'(cnt_q - CNT_W'(1));
      end
    end
  end

endmodule

// ----- src/lpht_back.sv -----
// Probe engine of the hash table: holds the slot memories, walks the probe path
// and applies gets, inserts and deletes. Depends on lpht_pkg; fed by lpht_queue.
module lpht_back #(
  parameter int unsigned MAX_SLOTS = 256,
  parameter int unsigned SIZE_W    = 9,
  parameter int unsigned IDX_W     = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [SIZE_W-1:0]    size_i,
  input  lpht_pkg::req_t       entry_i,
  input  logic [IDX_W-1:0]     home_i,
  input  lpht_pkg::fifo_stat_t stat_i,
  output logic                 pop_o,
  output logic                 clearing_o,
  output lpht_pkg::result_t    result_o
);

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_PROBE
  } bstate_e;

  logic [lpht_pkg::KEY_W-1:0] key_mem [MAX_SLOTS];
  logic [lpht_pkg::VAL_W-1:0] val_mem [MAX_SLOTS];
  logic [lpht_pkg::KEY_W-1:0] rd_key_q;
  logic [lpht_pkg::VAL_W-1:0] rd_val_q;

  bstate_e           state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  lpht_pkg::req_t    req_q, req_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SIZE_W-1:0] cnt_q, cnt_d;
  lpht_pkg::result_t res_q, res_d;

  logic                       rd_en, wr_en;
  logic [IDX_W-1:0]           rd_addr, wr_addr;
  logic [lpht_pkg::KEY_W-1:0] wr_key;
  logic [lpht_pkg::VAL_W-1:0] wr_val;
  logic [lpht_pkg::KEY_W-1:0] want;
  logic                       hit;
  logic [SIZE_W-1:0]          cnt_inc;
  logic [SIZE_W-1:0]          idx_inc;
  logic [IDX_W-1:0]           idx_wrap;

  // An insert looks for an empty slot; get and delete look for the key itself.
  assign want     = (req_q.op == lpht_pkg::REQ_INSERT) ? lpht_pkg::EMPTY_KEY : req_q.key;
  assign hit      = (rd_key_q == want);
  assign cnt_inc  = cnt_q + SIZE_W'(1);
  assign idx_inc  = SIZE_W'(idx_q) + SIZE_W'(1);
  assign idx_wrap = (idx_inc == size_i) ? '0 : idx_inc[IDX_W-1:0];

  assign clearing_o = (state_q == B_CLEAR);
  assign result_o   = res_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    req_d    = req_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    res_d    = '{done: 1'b0, read_value: lpht_pkg::NO_VALUE, ok: 1'b0};
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = idx_q;
    wr_en    = 1'b0;
    wr_addr  = idx_q;
    wr_key   = lpht_pkg::EMPTY_KEY;
    wr_val   = lpht_pkg::NO_VALUE;
    unique case (state_q)
      B_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = IDX_W'(clr_q + IDX_W'(1));
        if (clr_q == IDX_W'(MAX_SLOTS - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!stat_i.empty) begin
          pop_o = 1'b1;
          req_d = entry_i;
          idx_d = home_i;
          cnt_d = '0;
          if (entry_i.op == lpht_pkg::REQ_NONE) begin
            res_d.done = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = home_i;
            state_d = B_PROBE;
          end
        end
      end
      B_PROBE: begin
        if (hit) begin
          unique case (req_q.op)
            lpht_pkg::REQ_INSERT: begin
              wr_en  = 1'b1;
              wr_key = req_q.key;
              wr_val = req_q.value;
            end
            lpht_pkg::REQ_DELETE: begin
              wr_en = 1'b1;
            end
            lpht_pkg::REQ_GET: begin
              res_d.read_value = rd_val_q;
            end
            lpht_pkg::REQ_NONE: begin
            end
            default: begin
            end
          endcase
          res_d.done = 1'b1;
          res_d.ok   = 1'b1;
          state_d    = B_IDLE;
        end else if (cnt_inc == size_i) begin
          res_d.done = 1'b1;
          state_d    = B_IDLE;
        end else begin
          idx_d   = idx_wrap;
          cnt_d   = cnt_inc;
          rd_en   = 1'b1;
          rd_addr = idx_wrap;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      rd_key_q <= key_mem[rd_addr];
      rd_val_q <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
      req_q   <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      res_q   <= '{done: 1'b0, read_value: lpht_pkg::NO_VALUE, ok: 1'b0};
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      req_q   <= req_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      res_q   <= res_d;
    end
  end

endmodule

// ----- sim/tb_linear_probe_hash_table_top.sv -----
// Self-checking testbench of the linear-probing hash table top level.
// Depends on lpht_pkg and linear_probe_hash_table_top; it keeps a shadow copy of
// the slot store and checks every answer against it, field by field, in order.
module tb_linear_probe_hash_table_top;

  localparam int unsigned SLOTS        = 256;
  // Longest quiet stretch of a correct run: the clearing pass after reset, or a
  // full-table probe behind a few queued requests.
  localparam int unsigned STALL_LIMIT  = 3000;
  // A request can probe every slot, so this many cycles cover any late answer.
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [lpht_pkg::VAL_W-1:0] read_value;
    logic                       ok;
  } answer_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [1:0]                 req_type_i;
  logic [lpht_pkg::KEY_W-1:0] key_i;
  logic [lpht_pkg::VAL_W-1:0] value_i;
  logic                       done_o;
  logic [lpht_pkg::VAL_W-1:0] read_value_o;
  logic                       ok_o;
  logic                       cfg_we_i;
  logic [lpht_pkg::CFG_W-1:0] cfg_wdata_i;

  // Shadow of the slot store and of the size register.
  logic [lpht_pkg::KEY_W-1:0] shadow_keys   [SLOTS];
  logic [lpht_pkg::VAL_W-1:0] shadow_values [SLOTS];
  logic [lpht_pkg::CFG_W-1:0] shadow_size;

  // Answers owed by the block, oldest first.
  answer_t          answers_due [$];
  int unsigned      fail_count;
  int unsigned      quiet_cycles;
  logic             gaps_enabled;

  linear_probe_hash_table_top #(
    .MAX_SLOTS(SLOTS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .read_value_o(read_value_o),
    .ok_o        (ok_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Number of slots actually probed: a size of zero acts as one, and anything
  // above the store depth is clamped to it.
  function automatic int unsigned table_span();
    if (shadow_size == 0) return 1;
    if (shadow_size > SLOTS) return SLOTS;
    return shadow_size;
  endfunction

  // Applies one request to the shadow store and works out its answer. Gets and
  // deletes look for the request key, inserts look for an empty slot; the walk
  // starts at the home slot, wraps at the span and visits each slot once.
  function automatic void apply_to_shadow_table(
    input  lpht_pkg::req_e             op,
    input  logic [lpht_pkg::KEY_W-1:0] key,
    input  logic [lpht_pkg::VAL_W-1:0] val,
    output logic [lpht_pkg::VAL_W-1:0] read_value,
    output logic                       ok
  );
    int unsigned                span;
    int unsigned                idx;
    int                         hit;
    logic [lpht_pkg::KEY_W-1:0] want;
    span       = table_span();
    read_value = lpht_pkg::NO_VALUE;
    ok         = 1'b0;
    if (op == lpht_pkg::REQ_NONE) return;
    want = (op == lpht_pkg::REQ_INSERT) ? lpht_pkg::EMPTY_KEY : key;
    idx  = key % span;
    hit  = -1;
    for (int n = 0; n < span && hit < 0; n++) begin
      if (shadow_keys[idx] == want) begin
        hit = idx;
      end else begin
        idx = (idx + 1 == span) ? 0 : idx + 1;
      end
    end
    if (hit < 0) return;
    ok = 1'b1;
    case (op)
      lpht_pkg::REQ_GET: begin
        read_value = shadow_values[hit];
      end
      lpht_pkg::REQ_INSERT: begin
        shadow_keys[hit]   = key;
        shadow_values[hit] = val;
      end
      default: begin
        shadow_keys[hit]   = lpht_pkg::EMPTY_KEY;
        shadow_values[hit] = lpht_pkg::NO_VALUE;
      end
    endcase
  endfunction

  // Presents one request from the falling edge on and holds it until a rising
  // edge sees busy low. Start stays high when the next request follows at once;
  // otherwise a random gap of idle cycles is inserted.
  task automatic send_request(input lpht_pkg::req_e op,
                              input logic [lpht_pkg::KEY_W-1:0] key,
                              input logic [lpht_pkg::VAL_W-1:0] val);
    answer_t ans;
    @(negedge clk_i);
    start      <= 1'b1;
    req_type_i <= op;
    key_i      <= key;
    value_i    <= val;
    do @(posedge clk_i); while (busy);
    apply_to_shadow_table(op, key, val, ans.read_value, ans.ok);
    answers_due.push_back(ans);
    if (gaps_enabled && $urandom_range(99) < 34) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  endtask

  // Stops sending and waits until every owed answer has come back, so the
  // size register can be changed with nothing in flight.
  task automatic settle_table();
    @(negedge clk_i);
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_table_size(input logic [lpht_pkg::CFG_W-1:0] size);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_size = size;
  endtask

  // Home-slot hits and misses at the reset size, the extreme keys, the unused
  // request type, and a delete that finds nothing the second time.
  task automatic test_basic_requests();
    send_request(lpht_pkg::REQ_INSERT, 16'h0000, 16'h0000);
    send_request(lpht_pkg::REQ_INSERT, 16'hFFFE, 16'hA5A5);
    send_request(lpht_pkg::REQ_GET,    16'h0000, 16'h1111);
    send_request(lpht_pkg::REQ_GET,    16'hFFFE, 16'h0000);
    send_request(lpht_pkg::REQ_GET,    16'h00FF, 16'hFFFF);
    send_request(lpht_pkg::REQ_NONE,   16'h0000, 16'h5A5A);
    send_request(lpht_pkg::REQ_DELETE, 16'h0000, 16'h0000);
    send_request(lpht_pkg::REQ_DELETE, 16'h0000, 16'h0000);
  endtask

  // Four keys with the same home slot in a four-slot table: the run wraps to
  // slot zero, a fifth insert finds the table full, a miss walks every slot,
  // a get still finds its key past a hole, and a later insert fills the hole.
  task automatic test_probe_wrap_and_full();
    settle_table();
    write_table_size(9'd4);
    send_request(lpht_pkg::REQ_INSERT, 16'd3,  16'h0001);
    send_request(lpht_pkg::REQ_INSERT, 16'd7,  16'h0002);
    send_request(lpht_pkg::REQ_INSERT, 16'd11, 16'h0003);
    send_request(lpht_pkg::REQ_INSERT, 16'd15, 16'h0004);
    send_request(lpht_pkg::REQ_INSERT, 16'd19, 16'h0005);
    send_request(lpht_pkg::REQ_GET,    16'd19, 16'h0000);
    send_request(lpht_pkg::REQ_DELETE, 16'd7,  16'h0000);
    send_request(lpht_pkg::REQ_GET,    16'd11, 16'h0000);
    send_request(lpht_pkg::REQ_INSERT, 16'd19, 16'h0006);
  endtask

  // The empty marker used as a request key acts on the first empty slot.
  task automatic test_reserved_key();
    settle_table();
    write_table_size(9'd8);
    send_request(lpht_pkg::REQ_INSERT, lpht_pkg::EMPTY_KEY, 16'h1234);
    send_request(lpht_pkg::REQ_GET,    lpht_pkg::EMPTY_KEY, 16'h0000);
    send_request(lpht_pkg::REQ_DELETE, lpht_pkg::EMPTY_KEY, 16'h0000);
    send_request(lpht_pkg::REQ_GET,    lpht_pkg::EMPTY_KEY, 16'h0000);
  endtask

  // Size zero acts as one slot, and sizes above the depth are clamped; slots
  // outside a smaller size keep their contents and show up again later.
  task automatic test_size_limits();
    settle_table();
    write_table_size(9'd0);
    send_request(lpht_pkg::REQ_GET,    16'd19, 16'h0000);
    send_request(lpht_pkg::REQ_INSERT, 16'd5,  16'h7777);
    settle_table();
    write_table_size(9'd511);
    send_request(lpht_pkg::REQ_GET,    16'hFFFE, 16'h0000);
    settle_table();
    write_table_size(9'd257);
    send_request(lpht_pkg::REQ_GET,    lpht_pkg::EMPTY_KEY, 16'h0000);
  endtask

  // Random traffic in phases of different sizes. Keys come mostly from a small
  // pool, or from the pool shifted by a multiple of the size, so that inserts,
  // gets and deletes collide on the same runs; the rest is any key at all.
  task automatic test_random_traffic();
    int unsigned                phase_sizes [10] = '{2, 5, 1, 16, 3, 37, 256, 7, 511, 0};
    logic [lpht_pkg::KEY_W-1:0] pool [6];
    logic [lpht_pkg::KEY_W-1:0] key;
    lpht_pkg::req_e             op;
    int unsigned                pick;
    int unsigned                span;
    for (int p = 0; p < 10; p++) begin
      settle_table();
      if (p == 9) begin
        write_table_size(lpht_pkg::CFG_W'($urandom_range(0, 511)));
      end else begin
        write_table_size(lpht_pkg::CFG_W'(phase_sizes[p]));
      end
      span = table_span();
      // One phase runs back to back with no idle cycles at all.
      gaps_enabled = (p != 3);
      foreach (pool[i]) pool[i] = lpht_pkg::KEY_W'($urandom_range(0, 65534));
      repeat (105) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          op = lpht_pkg::REQ_INSERT;
        end else if (pick < 75) begin
          op = lpht_pkg::REQ_GET;
        end else if (pick < 95) begin
          op = lpht_pkg::REQ_DELETE;
        end else begin
          op = lpht_pkg::REQ_NONE;
        end
        pick = $urandom_range(99);
        if (pick < 60) begin
          key = pool[$urandom_range(5)];
        end else if (pick < 80) begin
          key = pool[$urandom_range(5)]
                + lpht_pkg::KEY_W'(span * $urandom_range(1, 3));
        end else if (pick < 93) begin
          key = lpht_pkg::KEY_W'($urandom_range(0, 65535));
        end else begin
          key = lpht_pkg::EMPTY_KEY;
        end
        send_request(op, key, lpht_pkg::VAL_W'($urandom_range(0, 65535)));
      end
    end
    gaps_enabled = 1'b1;
  endtask

  // Each answer is taken at the rising edge that ends its strobe cycle and is
  // matched against the oldest owed answer.
  always @(posedge clk_i) begin
    answer_t due;
    if (rst_ni && done_o) begin
      if (answers_due.size() == 0) begin
        $display("%0t: answer with none owed: read_value %h ok %b",
                 $time, read_value_o, ok_o);
        fail_count++;
      end else begin
        due = answers_due.pop_front();
        if (read_value_o !== due.read_value) begin
          $display("%0t: read_value expected %h actual %h",
                   $time, due.read_value, read_value_o);
          fail_count++;
        end
        if (ok_o !== due.ok) begin
          $display("%0t: ok expected %b actual %b", $time, due.ok, ok_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any accepted request or answer restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_type_i   = lpht_pkg::REQ_GET;
    key_i        = '0;
    value_i      = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    fail_count   = 0;
    quiet_cycles = 0;
    gaps_enabled = 1'b1;
    foreach (shadow_keys[i]) begin
      shadow_keys[i]   = lpht_pkg::EMPTY_KEY;
      shadow_values[i] = lpht_pkg::NO_VALUE;
    end
    shadow_size = lpht_pkg::SIZE_RESET;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_requests();
    test_probe_wrap_and_full();
    test_reserved_key();
    test_size_limits();
    test_random_traffic();

    // Let every owed answer arrive, then watch a while longer for strays.
    settle_table();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
